/* design/dep_pkg.sv */
// Package for the dictionary encoder with bit-packed indices.
// Holds the beat structs, mode, status and state codes and the index-width function.
// Used by dep_row, dictionary_encoder_bit_packed and dep_chk.
package dep_pkg;

  localparam int DictDepthDef = 256;
  localparam int MaxItemsDef  = 4096;
  localparam int ValueBitsDef = 32;
  localparam int GroupSize    = 16;
  localparam int ByteBits     = 8;
  localparam int ByteLast     = 7;
  localparam int AddrBits     = 12;

  typedef enum logic [2:0] {
    MD_LOAD  = 3'd0,
    MD_DICT  = 3'd1,
    MD_BYTE  = 3'd2,
    MD_STAT  = 3'd3,
    MD_CLEAR = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ITEMS = 2'd2,
    ST_ADDR  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CMP, S_GRP, S_SUM, S_LOAD, S_DRD, S_DIV, S_BRD, S_BIT, S_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [11:0] address;
  } in_t;

  typedef struct packed {
    logic [31:0] data;
    logic        is_new;
    status_t     status;
    logic [3:0]  bit_width;
    logic [8:0]  dict_count;
    logic [12:0] item_count;
    logic [12:0] byte_count;
  } out_t;

  // Smallest w with 2**w not below n for n up to 2**31, zero for n of zero or one.
  function automatic logic [5:0] width_of(input logic [31:0] n);
    logic [5:0] w;
    w = '0;
    for (int i = 0; i < 31; i++) begin
      if ((33'd1 << i) < {1'b0, n}) begin
        w = 6'(i + 1);
      end
    end
    return w;
  endfunction

endpackage

/* design/dep_cell.sv */
// One dictionary cell: holds one entry and compares it against the search key.
// Depends on nothing outside this file.
module dep_cell #(
  parameter int VW  = 32,
  parameter int CW  = 9,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          load_en,
  input  logic [VW-1:0] key,
  input  logic [CW-1:0] count,
  output logic          hit_r
);

  logic [VW-1:0] val_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      val_r <= key;
    end
    hit_r <= (32'(count) > IDX) && (val_r == key);
  end

endmodule

/* design/dep_row.sv */
// Row of dictionary cells with a registered two-level reduction of their hits.
// Depends on dep_pkg and dep_cell.
module dep_row
  import dep_pkg::*;
#(
  parameter int DEPTH = DictDepthDef,
  parameter int VW    = 32,
  parameter int DW    = 8,
  parameter int CW    = 9
) (
  input  logic          clk,
  input  logic [VW-1:0] key,
  input  logic [CW-1:0] count,
  input  logic          wr_en,
  input  logic [DW-1:0] wr_idx,
  output logic          found_r,
  output logic [DW-1:0] idx_r
);

  localparam int NG = (DEPTH + GroupSize - 1) / GroupSize;
  localparam int LW = $clog2(GroupSize);

  logic [NG*GroupSize-1:0] hitv;
  logic [NG-1:0]           grp_any_r;
  logic [LW-1:0]           grp_loc_r [NG];
  logic [NG-1:0]           grp_any;
  logic [LW-1:0]           grp_loc   [NG];
  logic                    found;
  logic [DW-1:0]           idx;

  for (genvar i = 0; i < NG * GroupSize; i++) begin : g_cell
    if (i < DEPTH) begin : g_live
      dep_cell #(.VW(VW), .CW(CW), .IDX(i)) u_cell (
        .clk    (clk),
        .load_en(wr_en && (32'(wr_idx) == i)),
        .key    (key),
        .count  (count),
        .hit_r  (hitv[i])
      );
    end else begin : g_pad
      assign hitv[i] = 1'b0;
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any[g] = 1'b0;
      grp_loc[g] = '0;
      for (int j = 0; j < GroupSize; j++) begin
        if (hitv[g*GroupSize+j]) begin
          grp_any[g] = 1'b1;
          grp_loc[g] = grp_loc[g] | LW'(j);
        end
      end
    end
  end

  always_comb begin
    found = |grp_any_r;
    idx   = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp_any_r[g]) begin
        idx = idx | DW'(g * GroupSize + int'(grp_loc_r[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any;
    grp_loc_r <= grp_loc;
    found_r   <= found;
    idx_r     <= idx;
  end

endmodule

/* design/dep_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module dep_div #(
  parameter int NW  = 15,
  parameter int DNW = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  output logic           done_r,
  output logic [NW-1:0]  quo_r,
  output logic [DNW-1:0] rem_r
);

  localparam int KW = $clog2(NW + 1);

  logic          busy_r;
  logic [KW-1:0] cnt_r;
  logic [DNW:0]  trial;
  logic          take;

  assign trial = {rem_r, quo_r[NW-1]};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= KW'(NW);
        quo_r  <= num;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= take ? DNW'(trial - {1'b0, den}) : DNW'(trial);
        quo_r <= {quo_r[NW-2:0], take};
        cnt_r <= cnt_r - KW'(1);
        if (cnt_r == KW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/dictionary_encoder_bit_packed.sv */
// Dictionary encoder with bit-packed indices: lookup cells, index memory, packing.
// Depends on dep_pkg, dep_row and dep_div.
//
// Input beats carry a mode, a value and an address on in_valid/in_ready; one
// result beat per input leaves on out_valid/out_ready from an output register.
// A load registers the value, compares it against every live cell at once,
// reduces the hits through two registered levels and then stores the index.
// A dictionary read passes through S_DRD; status and clear go straight to S_FIN.
// A packed byte read first divides the bit position by the index width in a
// serial divider, then fetches one index per bit from the index memory, passing
// through S_BRD and S_BIT for each of the eight bits of the byte.
// One item is worked on at a time; the next beat is accepted once the result
// has moved into the output register, even while that register still waits.
// When the receiver stalls, the result holds and a finished item waits.
// Reset empties the dictionary and the index list by clearing their counts;
// the stored entries are not cleared and are never read before being written.
module dictionary_encoder_bit_packed
  import dep_pkg::*;
#(
  parameter int DICT_DEPTH = DictDepthDef,
  parameter int MAX_ITEMS  = MaxItemsDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int SVB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int DW  = $clog2(DICT_DEPTH);
  localparam int SW  = (DW > 1) ? $clog2(DW) : 1;
  localparam int DCW = $clog2(DICT_DEPTH + 1);
  localparam int IW  = $clog2(MAX_ITEMS);
  localparam int IAW = (IW < 1) ? 1 : IW;
  localparam int LCW = $clog2(MAX_ITEMS + 1);
  localparam int PW  = $clog2(DW + 1);
  localparam int BCW = LCW + PW + 1;
  localparam int NW  = AddrBits + 3;
  localparam int ITW = ((IAW > NW) ? IAW : NW) + 1;

  state_t         state_r, state_nxt;
  logic [SVB-1:0] key_r;
  logic [DCW-1:0] dcount_r;
  logic [LCW-1:0] lcount_r;
  logic [31:0]    res_data_r;
  logic           res_new_r;
  status_t        res_st_r;
  logic [ITW-1:0] item_r;
  logic [PW-1:0]  pos_r;
  logic [2:0]     bcnt_r;
  logic [7:0]     byte_r;
  logic           out_valid_r;
  out_t           out_r;

  logic [SVB-1:0] dict_mem [DICT_DEPTH];
  logic [SVB-1:0] dict_rd_r;
  logic [DW-1:0]  idx_mem [MAX_ITEMS];
  logic [DW-1:0]  idx_rd_r;

  logic           in_fire, fin, items_full, dict_bad, byte_bad, dict_full;
  logic           found_r, store_new, store_any, div_start, div_done, bit_v;
  logic [DW-1:0]  idx_r, store_idx;
  logic [PW-1:0]  bw;
  logic [SW-1:0]  sel;
  logic [BCW-1:0] bytes;
  logic [NW-1:0]  quo;
  logic [PW-1:0]  rem;
  logic [7:0]     byte_nxt;

  assign in_fire    = in_valid && in_ready;
  assign fin        = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign bw         = PW'(width_of(32'(dcount_r)));
  assign bytes      = BCW'((BCW'(lcount_r) * BCW'(bw) + BCW'(ByteLast)) >> 3);
  assign items_full = 32'(lcount_r) >= MAX_ITEMS;
  assign dict_full  = 32'(dcount_r) >= DICT_DEPTH;
  assign dict_bad   = 32'(in_data.address) >= 32'(dcount_r);
  assign byte_bad   = 32'(in_data.address) >= 32'(bytes);
  assign store_new  = (state_r == S_LOAD) && !found_r && !dict_full;
  assign store_any  = (state_r == S_LOAD) && (found_r || !dict_full);
  assign store_idx  = found_r ? idx_r : DW'(dcount_r);
  assign div_start  = in_fire && (in_data.mode == MD_BYTE) && !byte_bad;
  assign sel        = SW'(bw - pos_r - PW'(1));
  assign bit_v      = (item_r < ITW'(lcount_r)) ? idx_rd_r[sel] : 1'b0;
  assign byte_nxt   = {byte_r[6:0], bit_v};
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  dep_row #(.DEPTH(DICT_DEPTH), .VW(SVB), .DW(DW), .CW(DCW)) u_row (
    .clk    (clk),
    .key    (key_r),
    .count  (dcount_r),
    .wr_en  (store_new),
    .wr_idx (DW'(dcount_r)),
    .found_r(found_r),
    .idx_r  (idx_r)
  );

  dep_div #(.NW(NW), .DNW(PW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({in_data.address, 3'b000}),
    .den   (bw),
    .done_r(div_done),
    .quo_r (quo),
    .rem_r (rem)
  );

  always_comb begin
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.mode)
            MD_LOAD: state_nxt = items_full ? S_FIN : S_CMP;
            MD_DICT: state_nxt = dict_bad ? S_FIN : S_DRD;
            MD_BYTE: state_nxt = byte_bad ? S_FIN : S_DIV;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_CMP:  state_nxt = S_GRP;
      S_GRP:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_FIN;
      S_DRD:  state_nxt = S_FIN;
      S_DIV:  state_nxt = div_done ? S_BRD : S_DIV;
      S_BRD:  state_nxt = S_BIT;
      S_BIT:  state_nxt = (bcnt_r == 3'(ByteLast)) ? S_FIN : S_BRD;
      S_FIN:  state_nxt = fin ? S_IDLE : S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dcount_r    <= '0;
      lcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && (in_data.mode == MD_CLEAR)) begin
        dcount_r <= '0;
        lcount_r <= '0;
      end
      if (store_any) begin
        lcount_r <= lcount_r + LCW'(1);
      end
      if (store_new) begin
        dcount_r <= dcount_r + DCW'(1);
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dict_rd_r <= dict_mem[DW'(in_data.address)];
    idx_rd_r  <= idx_mem[item_r[IAW-1:0]];
    if (store_new) begin
      dict_mem[DW'(dcount_r)] <= key_r;
    end
    if (store_any) begin
      idx_mem[lcount_r[IAW-1:0]] <= store_idx;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_r      <= in_data.value[SVB-1:0];
          res_data_r <= '0;
          res_new_r  <= 1'b0;
          if ((in_data.mode == MD_LOAD) && items_full) begin
            res_st_r <= ST_ITEMS;
          end else if (((in_data.mode == MD_DICT) && dict_bad) ||
                       ((in_data.mode == MD_BYTE) && byte_bad)) begin
            res_st_r <= ST_ADDR;
          end else begin
            res_st_r <= ST_OK;
          end
        end
      end
      S_LOAD: begin
        if (found_r || !dict_full) begin
          res_data_r <= 32'(store_idx);
          res_new_r  <= !found_r;
        end else begin
          res_st_r <= ST_FULL;
        end
      end
      S_DRD: res_data_r <= 32'(dict_rd_r);
      S_DIV: begin
        if (div_done) begin
          item_r <= ITW'(quo);
          pos_r  <= rem;
          bcnt_r <= '0;
          byte_r <= '0;
        end
      end
      S_BIT: begin
        byte_r <= byte_nxt;
        bcnt_r <= bcnt_r + 3'd1;
        if (pos_r == PW'(bw - PW'(1))) begin
          pos_r  <= '0;
          item_r <= item_r + ITW'(1);
        end else begin
          pos_r <= pos_r + PW'(1);
        end
        if (bcnt_r == 3'(ByteLast)) begin
          res_data_r <= 32'(byte_nxt);
        end
      end
      S_FIN: begin
        if (fin) begin
          out_r.data       <= res_data_r;
          out_r.is_new     <= res_new_r;
          out_r.status     <= res_st_r;
          out_r.bit_width  <= 4'(bw);
          out_r.dict_count <= 9'(dcount_r);
          out_r.item_count <= 13'(lcount_r);
          out_r.byte_count <= 13'(bytes);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/dep_chk.sv */
// Port-level checks for the dictionary encoder, attached by the bind at the end.
// Depends on dep_pkg and dictionary_encoder_bit_packed.
module dep_chk
  import dep_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result beat changed while stalled.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.data == '0) && !out_data.is_new)
    else $error("Error beat carries data.");

  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.dict_count <= 9'd1) |-> (out_data.bit_width == 4'd0))
    else $error("Nonzero width for a dictionary of at most one entry.");

  a_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_new |-> (out_data.status == ST_OK) && (out_data.dict_count != '0))
    else $error("New entry reported without a dictionary entry.");

endmodule

bind dictionary_encoder_bit_packed dep_chk u_dep_chk (.*);
